// ===== rtl/core/rlts_pkg.sv =====
// Package for the route latency table selector: item and result types,
// the cell-to-cell token, register indexes and reset values. No dependencies.
package rlts_pkg;

    localparam int unsigned TABLE_DEPTH = 16;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned NODE_W  = 32;
    localparam int unsigned LAT_W   = 14;
    localparam int unsigned PEN_W   = 6;
    localparam int unsigned HOPS_W  = 8;
    localparam int unsigned DELAY_W = 15;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_CAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_PENALTY = 2'd2;

    localparam logic [TIME_W-1:0] AGE_LIMIT_RST   = 32'd10000;
    localparam logic [LAT_W-1:0]  LATENCY_CAP_RST = 14'd10000;
    localparam logic [PEN_W-1:0]  HOP_PENALTY_RST = 6'd2;

    localparam logic        REQ_PROBE    = 1'b0;
    localparam logic        REQ_EXPIRE   = 1'b1;
    localparam logic [HOPS_W-1:0] UNKNOWN_HOPS = 8'd255;

    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] node_id;
        logic [TIME_W-1:0] sent_time;
        logic [TIME_W-1:0] now_ms;
        logic [HOPS_W-1:0] hop_count;
        logic [HOPS_W-1:0] hops_to_dest;
    } t_req;

    typedef struct packed {
        logic               route_found;
        logic [NODE_W-1:0]  best_node;
        logic [DELAY_W-1:0] best_delay;
        logic [HOPS_W-1:0]  best_hops;
        logic               table_full_drop;
    } t_rsp;

    // Running state handed from one cell to the next.
    typedef struct packed {
        logic               valid;
        logic               any_hit;
        logic               pending;
        logic               found;
        logic [DELAY_W-1:0] best_delay;
        logic [NODE_W-1:0]  best_node;
        logic [HOPS_W-1:0]  best_hops;
    } t_tok;

endpackage

// ===== rtl/core/rlts_req_if.sv =====
// Request channel of the route latency table selector.
// Depends on rlts_pkg for the item type.
interface rlts_req_if;
    logic              valid;
    logic              ready;
    rlts_pkg::t_req    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rlts_rsp_if.sv =====
// Result channel of the route latency table selector.
// Depends on rlts_pkg for the result type.
interface rlts_rsp_if;
    logic              valid;
    logic              ready;
    rlts_pkg::t_rsp    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rlts_cell.sv =====
// One table slot: holds a route entry, expires it, takes an insert from the
// passing token and folds its own cost into the running best. Uses rlts_pkg.
module rlts_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_exp_en,
    input  logic                          i_req_type,
    input  logic [rlts_pkg::NODE_W-1:0]   i_node,
    input  logic [rlts_pkg::TIME_W-1:0]   i_now,
    input  logic [rlts_pkg::HOPS_W-1:0]   i_dest,
    input  logic [rlts_pkg::LAT_W-1:0]    i_lat,
    input  logic [rlts_pkg::TIME_W-1:0]   i_age_limit,
    input  logic [rlts_pkg::PEN_W-1:0]    i_hop_penalty,
    input  rlts_pkg::t_tok                i_tok,
    output rlts_pkg::t_tok                o_tok,
    output logic                          o_hit
);

    logic                        r_valid;
    logic                        r_hit;
    logic [rlts_pkg::NODE_W-1:0] r_node;
    logic [rlts_pkg::LAT_W-1:0]  r_lat;
    logic [rlts_pkg::TIME_W-1:0] r_seen;
    logic [rlts_pkg::HOPS_W-1:0] r_dest;
    rlts_pkg::t_tok              r_tok;
    rlts_pkg::t_tok              n_tok;

    logic [rlts_pkg::TIME_W-1:0]  w_age;
    logic                         w_expired;
    logic                         w_take;
    logic                         w_v;
    logic [rlts_pkg::NODE_W-1:0]  w_node;
    logic [rlts_pkg::LAT_W-1:0]   w_lat;
    logic [rlts_pkg::HOPS_W-1:0]  w_dest;
    logic                         w_usable;
    logic [rlts_pkg::LAT_W-1:0]   w_pen_cost;
    logic [rlts_pkg::DELAY_W-1:0] w_eff;
    logic                         w_better;

    assign w_age     = i_now - r_seen;
    assign w_expired = r_valid && (w_age > i_age_limit);

    // A hit rewrites its own slot; otherwise the first free slot claims the insert.
    assign w_take = i_tok.valid && i_tok.pending && (i_tok.any_hit ? r_hit : !r_valid);

    assign w_v    = r_valid || w_take;
    assign w_node = w_take ? i_node : r_node;
    assign w_lat  = w_take ? i_lat  : r_lat;
    assign w_dest = w_take ? i_dest : r_dest;

    assign w_usable   = w_v && (w_dest != rlts_pkg::UNKNOWN_HOPS);
    assign w_pen_cost = i_hop_penalty * w_dest;
    assign w_eff      = {1'b0, w_lat} + {1'b0, w_pen_cost};
    assign w_better   = w_usable && (!i_tok.found || (w_eff < i_tok.best_delay));

    always_comb begin
        n_tok         = i_tok;
        n_tok.pending = i_tok.pending && !w_take;
        if (w_better) begin
            n_tok.found      = 1'b1;
            n_tok.best_delay = w_eff;
            n_tok.best_node  = w_node;
            n_tok.best_hops  = w_dest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_exp_en) begin
                r_valid <= r_valid && !w_expired;
                r_hit   <= r_valid && !w_expired && (r_node == i_node)
                           && (i_req_type == rlts_pkg::REQ_PROBE);
            end else if (w_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_node <= i_node;
            r_lat  <= i_lat;
            r_seen <= i_now;
            r_dest <= i_dest;
        end
    end

    assign o_tok = r_tok;
    assign o_hit = r_hit;

endmodule

// ===== rtl/core/route_latency_table_selector_top.sv =====
// Route latency table selector, top level. Uses rlts_pkg, rlts_req_if,
// rlts_rsp_if and rlts_cell.
// A request passes the expire and launch states, then the token walks the row of
// cells one slot per cycle and the result is registered as it leaves the last cell.
// One item at a time: a new request is taken only when the sequencer is idle.
// Reset clears all slots (entries invalid) and loads the register defaults.
module route_latency_table_selector_top #(
    parameter int unsigned TABLE_DEPTH = rlts_pkg::TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rlts_req_if.sink                          i_req,
    rlts_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [rlts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rlts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Sequencer: take the request, expire in every cell, launch the token,
    // wait for it to leave the last cell, then hand the result to the output.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXP    = 3'd1;
    localparam logic [2:0] ST_LAUNCH = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [rlts_pkg::TIME_W-1:0] r_age_limit;
    logic [rlts_pkg::LAT_W-1:0]  r_lat_cap;
    logic [rlts_pkg::PEN_W-1:0]  r_hop_penalty;

    rlts_pkg::t_req              r_item;
    logic [rlts_pkg::LAT_W-1:0]  r_lat;
    rlts_pkg::t_rsp              r_res;
    rlts_pkg::t_rsp              r_out;
    logic                        r_out_valid;

    logic [rlts_pkg::TIME_W-1:0] w_diff;
    logic [rlts_pkg::TIME_W-1:0] w_mag;
    logic [rlts_pkg::LAT_W-1:0]  w_lat;
    logic                        w_in_beat;
    logic                        w_out_load;

    rlts_pkg::t_tok              w_tok [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0]      w_hit;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit   <= rlts_pkg::AGE_LIMIT_RST;
            r_lat_cap     <= rlts_pkg::LATENCY_CAP_RST;
            r_hop_penalty <= rlts_pkg::HOP_PENALTY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rlts_pkg::CFG_AGE_LIMIT: begin
                    r_age_limit <= i_cfg_data;
                end
                rlts_pkg::CFG_LATENCY_CAP: begin
                    r_lat_cap <= i_cfg_data[rlts_pkg::LAT_W-1:0];
                end
                rlts_pkg::CFG_HOP_PENALTY: begin
                    r_hop_penalty <= i_cfg_data[rlts_pkg::PEN_W-1:0];
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- intake
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_in_beat   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_item <= i_req.data;
        end
    end

    // Measured latency: magnitude of the signed wrap-around difference, capped.
    // Computed once during the expire cycle and held for the whole walk.
    assign w_diff = r_item.now_ms - r_item.sent_time;
    assign w_mag  = w_diff[rlts_pkg::TIME_W-1] ? (~w_diff + 32'd1) : w_diff;
    assign w_lat  = (w_mag > {{(rlts_pkg::TIME_W-rlts_pkg::LAT_W){1'b0}}, r_lat_cap})
                    ? r_lat_cap : w_mag[rlts_pkg::LAT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXP) begin
            r_lat <= w_lat;
        end
    end

    // ---------------------------------------------------------------- cell row
    // The token enters cell 0 during the launch cycle. It carries whether any
    // slot matched the node id (found during the expire cycle), whether the
    // insert is still pending, and the best route seen so far. A pending
    // insert on leaving the last cell means the table was full.
    always_comb begin
        w_tok[0]         = '0;
        w_tok[0].valid   = (r_state == ST_LAUNCH);
        w_tok[0].any_hit = |w_hit;
        w_tok[0].pending = (r_item.req_type == rlts_pkg::REQ_PROBE);
    end

    // Hop count is not needed by any result, so the cells do not keep it.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rlts_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_exp_en      (r_state == ST_EXP),
            .i_req_type    (r_item.req_type),
            .i_node        (r_item.node_id),
            .i_now         (r_item.now_ms),
            .i_dest        (r_item.hops_to_dest),
            .i_lat         (r_lat),
            .i_age_limit   (r_age_limit),
            .i_hop_penalty (r_hop_penalty),
            .i_tok         (w_tok[g]),
            .o_tok         (w_tok[g+1]),
            .o_hit         (w_hit[g])
        );
    end

    // ---------------------------------------------------------------- sequencer
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_beat) n_state = ST_EXP;
            end
            ST_EXP: begin
                n_state = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_tok[TABLE_DEPTH].valid) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the token as it leaves the last cell.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && w_tok[TABLE_DEPTH].valid) begin
            r_res.route_found     <= w_tok[TABLE_DEPTH].found;
            r_res.best_node       <= w_tok[TABLE_DEPTH].best_node;
            r_res.best_delay      <= w_tok[TABLE_DEPTH].best_delay;
            r_res.best_hops       <= w_tok[TABLE_DEPTH].best_hops;
            r_res.table_full_drop <= w_tok[TABLE_DEPTH].pending;
        end
    end

    // ---------------------------------------------------------------- output
    // Hold the result beat until taken; the next request may already be in work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule
